// ===== rtl/resp_command_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer's checker.
// No dependencies; include once per file that asserts.
`ifndef RESP_COMMAND_TOKENIZER_DEFINES_SVH
`define RESP_COMMAND_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RCT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rct: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rct: next-cycle check failed");

`endif

// ===== rtl/rct_pkg.sv =====
// Shared types and constants of the command tokenizer.
// No dependencies; imported by every module of the block but the checker.
package rct_pkg;

  localparam int DEFAULT_COUNT_WIDTH = 16;
  localparam int DEFAULT_LEN_WIDTH   = 32;

  localparam int BYTE_W     = 8;
  localparam int TOKNUM_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              message_end;
  } rct_item_t;

  typedef struct packed {
    logic                has_byte;
    logic [BYTE_W-1:0]   token_byte;
    logic [TOKNUM_W-1:0] token_number;
    logic                ends_token;
    logic                ends_message;
    logic [STATUS_W-1:0] status;
  } rct_result_t;

endpackage

// ===== rtl/rct_in_stage.sv =====
// Input register of the tokenizer: holds one accepted byte until the parser takes it.
// Depends on rct_pkg.
module rct_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rct_pkg::rct_item_t in_item,
  input  logic              take,
  output logic              hold_valid,
  output rct_pkg::rct_item_t hold_item
);
  import rct_pkg::*;

  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

// ===== rtl/rct_parser.sv =====
// Parse state and per-byte next-state logic of the tokenizer.
// Depends on rct_pkg; produces at most one result per byte.
module rct_parser #(
  parameter int COUNT_WIDTH = rct_pkg::DEFAULT_COUNT_WIDTH,
  parameter int LEN_WIDTH   = rct_pkg::DEFAULT_LEN_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  rct_pkg::rct_item_t   item,
  output logic                 res_valid,
  output rct_pkg::rct_result_t res
);
  import rct_pkg::*;

  localparam int ACC_W = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
  localparam int EXT_W = ACC_W + 4;

  localparam logic [3:0] PH_MODE   = 4'd0;
  localparam logic [3:0] PH_CNT0   = 4'd1;
  localparam logic [3:0] PH_CNT    = 4'd2;
  localparam logic [3:0] PH_CNTLF  = 4'd3;
  localparam logic [3:0] PH_ELEM   = 4'd4;
  localparam logic [3:0] PH_LEN0   = 4'd5;
  localparam logic [3:0] PH_LEN    = 4'd6;
  localparam logic [3:0] PH_LENLF  = 4'd7;
  localparam logic [3:0] PH_PAY    = 4'd8;
  localparam logic [3:0] PH_SKIP1  = 4'd9;
  localparam logic [3:0] PH_SKIP2  = 4'd10;
  localparam logic [3:0] PH_DONE   = 4'd11;
  localparam logic [3:0] PH_INLINE = 4'd12;

  localparam logic [EXT_W-1:0] COUNT_LIMIT = EXT_W'((EXT_W'(1) << COUNT_WIDTH) - EXT_W'(1));
  localparam logic [EXT_W-1:0] LEN_LIMIT   = EXT_W'((EXT_W'(1) << LEN_WIDTH) - EXT_W'(1));

  logic [3:0]             phase, phase_next;
  logic [COUNT_WIDTH-1:0] elements_left, elements_left_next;
  logic [LEN_WIDTH-1:0]   bytes_left, bytes_left_next;
  logic [ACC_W-1:0]       number_accum, number_accum_next;
  logic [TOKNUM_W-1:0]    token_count, token_count_next;
  logic                   inside_token, inside_token_next;
  logic                   parse_stopped, parse_stopped_next;

  logic [BYTE_W-1:0] b;
  logic              is_end, is_digit, is_space;
  logic [3:0]        work;
  logic [EXT_W-1:0]  times_ten;
  logic [EXT_W-1:0]  limit;
  logic [ACC_W-1:0]  accum_sat;
  logic              has, et, stop;
  logic [STATUS_W-1:0] status;

  assign b        = item.data_byte;
  assign is_end   = item.message_end;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

  // acc * 10 + digit by shift and add, saturated at the field's width
  assign times_ten = (EXT_W'(number_accum) << 3) + (EXT_W'(number_accum) << 1)
                     + EXT_W'(b[3:0]);
  assign limit     = (phase == PH_CNT) ? COUNT_LIMIT : LEN_LIMIT;
  assign accum_sat = (times_ten > limit) ? limit[ACC_W-1:0] : times_ten[ACC_W-1:0];

  always_comb begin
    phase_next         = phase;
    elements_left_next = elements_left;
    bytes_left_next    = bytes_left;
    number_accum_next  = number_accum;
    inside_token_next  = inside_token;
    parse_stopped_next = parse_stopped;
    has  = 1'b0;
    et   = 1'b0;
    stop = 1'b0;
    // the first byte of a message that is not '*' is already inline text
    work = (phase == PH_MODE) ? PH_INLINE : phase;

    if ((phase == PH_MODE) && (b == CH_STAR)) begin
      phase_next        = PH_CNT0;
      number_accum_next = '0;
    end else begin
      // stay in whitespace mode for the rest of the message
      if (phase == PH_MODE) begin
        phase_next = PH_INLINE;
      end
      unique case (work)
        PH_INLINE: begin
          if (is_space) begin
            if (inside_token) begin
              et = 1'b1;
              inside_token_next = 1'b0;
            end
          end else begin
            has = 1'b1;
            inside_token_next = 1'b1;
          end
          if (is_end && inside_token_next) begin
            et = 1'b1;
            inside_token_next = 1'b0;
          end
        end
        PH_CNT0, PH_LEN0: begin
          if (is_digit) begin
            number_accum_next = ACC_W'(b[3:0]);
            phase_next = (work == PH_CNT0) ? PH_CNT : PH_LEN;
          end else begin
            stop = 1'b1;
          end
        end
        PH_CNT, PH_LEN: begin
          if (is_digit) begin
            number_accum_next = accum_sat;
          end else if (b == CH_CR) begin
            phase_next = (work == PH_CNT) ? PH_CNTLF : PH_LENLF;
          end else begin
            stop = 1'b1;
          end
        end
        PH_CNTLF: begin
          if (b == CH_LF) begin
            elements_left_next = number_accum[COUNT_WIDTH-1:0];
            phase_next = (number_accum[COUNT_WIDTH-1:0] != '0) ? PH_ELEM : PH_DONE;
          end else begin
            stop = 1'b1;
          end
        end
        PH_ELEM: begin
          if (b == CH_DOLLAR) begin
            elements_left_next = elements_left - COUNT_WIDTH'(1);
            number_accum_next  = '0;
            phase_next         = PH_LEN0;
          end else begin
            stop = 1'b1;
          end
        end
        PH_LENLF: begin
          if (b == CH_LF) begin
            if (number_accum[LEN_WIDTH-1:0] == '0) begin
              et = 1'b1;
              phase_next = PH_SKIP1;
            end else begin
              bytes_left_next   = number_accum[LEN_WIDTH-1:0];
              inside_token_next = 1'b1;
              phase_next        = PH_PAY;
            end
          end else begin
            stop = 1'b1;
          end
        end
        PH_PAY: begin
          has = 1'b1;
          bytes_left_next = bytes_left - LEN_WIDTH'(1);
          if (bytes_left == LEN_WIDTH'(1)) begin
            et = 1'b1;
            inside_token_next = 1'b0;
            phase_next = PH_SKIP1;
          end
        end
        PH_SKIP1: phase_next = PH_SKIP2;
        PH_SKIP2: phase_next = (elements_left != '0) ? PH_ELEM : PH_DONE;
        default: ;
      endcase
    end

    if (stop) begin
      parse_stopped_next = 1'b1;
      phase_next = PH_DONE;
    end

    token_count_next = et ? token_count + TOKNUM_W'(1) : token_count;

    status = ST_OK;
    if (is_end) begin
      priority if (parse_stopped_next ||
                   ((phase_next >= PH_CNT0) && (phase_next <= PH_CNTLF)) ||
                   ((phase_next >= PH_LEN0) && (phase_next <= PH_LENLF))) begin
        status = ST_MALFORMED;
      end else if (phase_next == PH_PAY) begin
        status = ST_TRUNCATED;
      end else if (token_count_next == '0) begin
        status = ST_EMPTY;
      end else begin
        status = ST_OK;
      end
    end
  end

  assign res_valid        = has || et || is_end;
  assign res.has_byte     = has;
  assign res.token_byte   = has ? b : '0;
  // with no token ended here the count is unchanged, so the old count serves every case
  assign res.token_number = token_count;
  assign res.ends_token   = et;
  assign res.ends_message = is_end;
  assign res.status       = status;

  always_ff @(posedge clk) begin
    if (rst || (step && is_end)) begin
      phase         <= PH_MODE;
      elements_left <= '0;
      bytes_left    <= '0;
      number_accum  <= '0;
      token_count   <= '0;
      inside_token  <= 1'b0;
      parse_stopped <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      elements_left <= elements_left_next;
      bytes_left    <= bytes_left_next;
      number_accum  <= number_accum_next;
      token_count   <= token_count_next;
      inside_token  <= inside_token_next;
      parse_stopped <= parse_stopped_next;
    end
  end

endmodule

// ===== rtl/rct_out_stage.sv =====
// Result register of the tokenizer: holds one result until the sink takes it.
// Depends on rct_pkg.
module rct_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  rct_pkg::rct_result_t load_res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rct_pkg::rct_result_t out_res
);
  import rct_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

// ===== rtl/resp_command_tokenizer.sv =====
// Top level of the command tokenizer: input register, parser, result register.
// Depends on rct_pkg, rct_in_stage, rct_parser and rct_out_stage.
//
// Usage:
//  - Feed the command message one byte per transfer on s_axis; s_axis_tlast marks
//    the message's last byte. A message opening with '*' is parsed as an array of
//    length-prefixed strings, any other message is split at whitespace.
//  - Each byte yields zero or one result transfer on m_axis: a payload byte
//    (m_axis_tuser high), a token end, and always one result for the last byte,
//    flagged by m_axis_tlast and carrying the message status.
//  - A byte is held in the input register, then its parse result is loaded into
//    the result register, from which it is offered on m_axis.
//  - Throughput: one byte per cycle while the sink does not stall, set by the parse
//    step between the two registers; bytes that give no result still pass through it.
//  - When the sink stalls, hold the result; the input register keeps one more
//    byte and s_axis_tready drops until the result register frees.
//  - Reset (rst, synchronous) empties both registers and returns the parser to
//    the start of a message; the last byte of a message also returns the parser there.
module resp_command_tokenizer #(
  parameter int COUNT_WIDTH = rct_pkg::DEFAULT_COUNT_WIDTH,
  parameter int LEN_WIDTH   = rct_pkg::DEFAULT_LEN_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rct_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tlast,  // message_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] token_byte, [23:8] token_number, [24] ends_token, [26:25] status, zeros above
  output logic [rct_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,  // ends_message
  output logic                            m_axis_tuser   // has_byte
);
  import rct_pkg::*;

  rct_item_t   in_item;
  rct_item_t   hold_item;
  logic        hold_valid;
  logic        fire;
  logic        out_free;
  logic        res_valid;
  rct_result_t res;
  rct_result_t out_res;

  assign in_item.data_byte   = s_axis_tdata;
  assign in_item.message_end = s_axis_tlast;

  // advance the held byte whenever the result register can take its result
  assign fire = hold_valid && out_free;

  rct_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  rct_parser #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .LEN_WIDTH   (LEN_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .item      (hold_item),
    .res_valid (res_valid),
    .res       (res)
  );

  rct_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .load_res  (res),
    .free      (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.status, out_res.ends_token,
                         out_res.token_number, out_res.token_byte};
  assign m_axis_tlast = out_res.ends_message;
  assign m_axis_tuser = out_res.has_byte;

endmodule

// ===== rtl/rct_checker.sv =====
// Port-level checks of the command tokenizer, bound to its top level.
// Depends on resp_command_tokenizer_defines.svh.
`include "resp_command_tokenizer_defines.svh"

module rct_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // a stalled result holds
  `RCT_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

  // a result without payload carries a zero byte
  `RCT_ASSERT_NOW(a_zero_byte, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'h00)

  // status only on the message's last result
  `RCT_ASSERT_NOW(a_status_last, clk, rst, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[26:25] == 2'b00)

  // the first result after a message end starts the token numbering over
  `RCT_ASSERT_NEXT(a_renumber, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid || (m_axis_tdata[23:8] == 16'h0000))

endmodule

bind resp_command_tokenizer rct_checker u_rct_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
